[sv/tmc2d_pkg.sv]
// shared types and constants for the two-means clustering unit
package tmc2d_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEED,
        ST_SEED_WAIT,
        ST_PASS,
        ST_PASS_WAIT,
        ST_DIV,
        ST_CHECK,
        ST_OUT,
        ST_OUT_WAIT
    } state_t;

    localparam logic [0:0] CFG_MAX_ITER = 1'b0;
    localparam logic [7:0] MAX_ITER_RESET = 8'd64;

endpackage

[sv/tmc2d_ram.sv]
// generic single-port ram with registered read
module tmc2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[sv/tmc2d_div.sv]
// restoring divider for signed sum by unsigned count, truncating toward zero
module tmc2d_div #(
    parameter int NW = 23,
    parameter int DW = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 busy,
    output logic signed [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            neg_next = num[NW-1];
            q_next = num[NW-1] ? NW'(-num) : num;
            r_next = '0;
            d_next = den;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quo = neg_reg ? NW'(-q_reg) : q_reg;

endmodule

[sv/two_means_clustering_2d_unit.sv]
// top level of the two-means clustering unit
// Points load one per cycle into on-chip memory; up to MAX_POINTS are kept and
// further points are dropped. The transaction marked tlast starts clustering
// and no input is taken until all results have gone out. Seeding reads the set
// once. Each pass alternates a read and a write-back of every point through the
// one memory port, then divides the four sums bit-serially and runs the
// convergence check. Output then streams one result per point at up to one per
// cycle, slowed only by m_axis_tready back-pressure.
module two_means_clustering_2d_unit #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // point_x, point_y
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // point_index[5:0], cluster, mean_a_x, mean_a_y, mean_b_x, mean_b_y,
    // limit_hit, empty_cluster
    output logic [((9+4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int CW = COORD_WIDTH;
    localparam int SW = CW + CNTW;
    localparam int MW = 2 * CW + 1;
    localparam int ODW = ((9+4*CW+7)/8)*8;

    tmc2d_pkg::state_t st_reg, st_next;

    logic [7:0]       max_iter_reg;
    logic [CNTW-1:0]  count_reg, count_next;
    logic [CNTW-1:0]  idx_reg, idx_next;
    logic signed [CW-1:0] mean_reg [4];
    logic signed [CW-1:0] mean_next [4];
    logic signed [SW-1:0] sum_reg [4];
    logic signed [SW-1:0] sum_next [4];
    logic [CNTW-1:0]  mcnt_reg [2];
    logic [CNTW-1:0]  mcnt_next [2];
    logic [7:0]       pass_reg, pass_next;
    logic             chg_reg, chg_next;
    logic             limit_reg, limit_next;
    logic signed [CW:0] lo_s_reg, lo_s_next, hi_s_reg, hi_s_next;
    logic [1:0]       dsel_reg, dsel_next;
    logic             dstart;
    logic             rd_v_reg, rd_v_next;
    logic [CNTW-1:0]  rd_i_reg, rd_i_next;
    logic             ovalid_reg, ovalid_next;
    logic [ODW-1:0]   odata_reg, odata_next;
    logic             olast_reg, olast_next;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [MW-1:0]    mem_wdata, mem_rdata;
    logic signed [CW-1:0] rx, ry;
    logic             rlab;

    logic             in_acc, out_acc, last_pass;
    logic signed [CW:0] s_sum;
    logic signed [CW:0] dax, day, dbx, dby;
    logic [2*CW+2:0]  da, db;
    logic             lab;
    logic signed [SW-1:0] dnum;
    logic [CNTW-1:0]  dden;
    logic             dbusy;
    logic signed [SW-1:0] dquo;

    assign pready = 1'b1;
    assign prdata = {24'd0, max_iter_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= tmc2d_pkg::MAX_ITER_RESET;
        end
        else if (psel && penable && pwrite && paddr == {tmc2d_pkg::CFG_MAX_ITER, 1'b0})
        begin
            max_iter_reg <= pwdata[7:0];
        end
    end

    tmc2d_ram #(.WIDTH(MW), .DEPTH(MAX_POINTS)) u_ram (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    assign rx = mem_rdata[CW-1:0];
    assign ry = mem_rdata[2*CW-1:CW];
    assign rlab = mem_rdata[2*CW];
    assign s_sum = (CW+1)'(rx) + (CW+1)'(ry);
    assign dax = (CW+1)'(rx) - (CW+1)'(mean_reg[0]);
    assign day = (CW+1)'(ry) - (CW+1)'(mean_reg[1]);
    assign dbx = (CW+1)'(rx) - (CW+1)'(mean_reg[2]);
    assign dby = (CW+1)'(ry) - (CW+1)'(mean_reg[3]);
    assign da = (2*CW+3)'(dax * dax) + (2*CW+3)'(day * day);
    assign db = (2*CW+3)'(dbx * dbx) + (2*CW+3)'(dby * dby);
    assign lab = !(da < db);

    assign dnum = sum_reg[dsel_reg];
    assign dden = mcnt_reg[dsel_reg[1]];

    tmc2d_div #(.NW(SW), .DW(CNTW)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(dstart),
        .num  (dnum),
        .den  (dden),
        .busy (dbusy),
        .quo  (dquo)
    );

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (st_reg == tmc2d_pkg::ST_LOAD);
    assign last_pass = ((pass_reg + 8'd1) >= max_iter_reg) || !chg_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            tmc2d_pkg::ST_LOAD:
                if (in_acc && s_axis_tlast) st_next = tmc2d_pkg::ST_SEED;
            tmc2d_pkg::ST_SEED:
                if (idx_reg == count_reg) st_next = tmc2d_pkg::ST_SEED_WAIT;
            tmc2d_pkg::ST_SEED_WAIT:
                st_next = tmc2d_pkg::ST_PASS;
            tmc2d_pkg::ST_PASS:
                if (idx_reg == count_reg) st_next = tmc2d_pkg::ST_PASS_WAIT;
            tmc2d_pkg::ST_PASS_WAIT:
                if (!rd_v_reg) st_next = tmc2d_pkg::ST_DIV;
            tmc2d_pkg::ST_DIV:
                if (!dbusy && !dstart && dsel_reg == 2'd3 && idx_reg[0])
                    st_next = tmc2d_pkg::ST_CHECK;
            tmc2d_pkg::ST_CHECK:
                st_next = last_pass ? tmc2d_pkg::ST_OUT : tmc2d_pkg::ST_PASS;
            tmc2d_pkg::ST_OUT:
                if (idx_reg == count_reg) st_next = tmc2d_pkg::ST_OUT_WAIT;
            tmc2d_pkg::ST_OUT_WAIT:
                if (!rd_v_reg && !ovalid_reg) st_next = tmc2d_pkg::ST_LOAD;
            default:
                st_next = tmc2d_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next = idx_reg;
        mean_next = mean_reg;
        sum_next = sum_reg;
        mcnt_next = mcnt_reg;
        pass_next = pass_reg;
        chg_next = chg_reg;
        limit_next = limit_reg;
        lo_s_next = lo_s_reg;
        hi_s_next = hi_s_reg;
        dsel_next = dsel_reg;
        dstart = 1'b0;
        rd_v_next = 1'b0;
        rd_i_next = idx_reg;
        ovalid_next = ovalid_reg && !out_acc;
        odata_next = odata_reg;
        olast_next = olast_reg;
        mem_we = 1'b0;
        mem_addr = idx_reg[AW-1:0];
        mem_wdata = {1'b0, s_axis_tdata[2*CW-1:0]};
        unique case (st_reg)
            tmc2d_pkg::ST_LOAD:
            begin
                mem_addr = count_reg[AW-1:0];
                if (in_acc && count_reg != CNTW'(MAX_POINTS))
                begin
                    mem_we = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                idx_next = '0;
            end
            tmc2d_pkg::ST_SEED, tmc2d_pkg::ST_SEED_WAIT:
            begin
                if (st_reg == tmc2d_pkg::ST_SEED && idx_reg != count_reg)
                begin
                    rd_v_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_v_reg)
                begin
                    if (rd_i_reg == '0 || s_sum < lo_s_reg)
                    begin
                        lo_s_next = s_sum;
                        mean_next[0] = rx;
                        mean_next[1] = ry;
                    end
                    if (rd_i_reg == '0 || s_sum > hi_s_reg)
                    begin
                        hi_s_next = s_sum;
                        mean_next[2] = rx;
                        mean_next[3] = ry;
                    end
                end
                if (st_reg == tmc2d_pkg::ST_SEED_WAIT)
                begin
                    idx_next = '0;
                    pass_next = '0;
                    chg_next = 1'b1;
                    sum_next = '{default: '0};
                    mcnt_next = '{default: '0};
                end
            end
            tmc2d_pkg::ST_PASS, tmc2d_pkg::ST_PASS_WAIT:
            begin
                if (rd_v_reg)
                begin
                    mem_addr = rd_i_reg[AW-1:0];
                    mem_we = 1'b1;
                    mem_wdata = {lab, ry, rx};
                    if (lab != rlab) chg_next = 1'b1;
                    sum_next[{lab, 1'b0}] = sum_reg[{lab, 1'b0}] + SW'(rx);
                    sum_next[{lab, 1'b1}] = sum_reg[{lab, 1'b1}] + SW'(ry);
                    mcnt_next[lab] = mcnt_reg[lab] + 1'b1;
                end
                else if (st_reg == tmc2d_pkg::ST_PASS && idx_reg != count_reg)
                begin
                    rd_v_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                dsel_next = '0;
                if (st_reg == tmc2d_pkg::ST_PASS_WAIT) idx_next = '0;
            end
            tmc2d_pkg::ST_DIV:
            begin
                // idx_reg[0] marks divider launched for current sum
                if (!idx_reg[0])
                begin
                    dstart = 1'b1;
                    idx_next = CNTW'(1);
                end
                else if (!dbusy)
                begin
                    mean_next[dsel_reg] = (mcnt_reg[dsel_reg[1]] == '0) ? '0 : CW'(dquo);
                    idx_next = '0;
                    dsel_next = dsel_reg + 1'b1;
                end
            end
            tmc2d_pkg::ST_CHECK:
            begin
                pass_next = pass_reg + 1'b1;
                limit_next = chg_reg;
                chg_next = 1'b0;
                idx_next = '0;
                if (!last_pass)
                begin
                    sum_next = '{default: '0};
                    mcnt_next = '{default: '0};
                end
            end
            tmc2d_pkg::ST_OUT, tmc2d_pkg::ST_OUT_WAIT:
            begin
                if (rd_v_reg && !ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    odata_next = ODW'({
                        (mcnt_reg[0] == '0) || (mcnt_reg[1] == '0), limit_reg,
                        mean_reg[3], mean_reg[2], mean_reg[1], mean_reg[0],
                        rlab, 6'(rd_i_reg)});
                    olast_next = (rd_i_reg + 1'b1 == count_reg);
                end
                else if (rd_v_reg)
                begin
                    rd_v_next = 1'b1;
                    rd_i_next = rd_i_reg;
                    mem_addr = rd_i_reg[AW-1:0];
                end
                if (st_reg == tmc2d_pkg::ST_OUT && idx_reg != count_reg && !rd_v_next
                    && !(rd_v_reg && ovalid_reg && !m_axis_tready))
                begin
                    rd_v_next = 1'b1;
                    rd_i_next = idx_reg;
                    mem_addr = idx_reg[AW-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                if (st_reg == tmc2d_pkg::ST_OUT_WAIT && st_next == tmc2d_pkg::ST_LOAD)
                    count_next = '0;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= tmc2d_pkg::ST_LOAD;
            count_reg <= '0;
            idx_reg <= '0;
            pass_reg <= '0;
            chg_reg <= 1'b1;
            limit_reg <= 1'b0;
            dsel_reg <= '0;
            rd_v_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            mean_reg <= '{default: '0};
            sum_reg <= '{default: '0};
            mcnt_reg <= '{default: '0};
        end
        else
        begin
            st_reg <= st_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            pass_reg <= pass_next;
            chg_reg <= chg_next;
            limit_reg <= limit_next;
            dsel_reg <= dsel_next;
            rd_v_reg <= rd_v_next;
            ovalid_reg <= ovalid_next;
            mean_reg <= mean_next;
            sum_reg <= sum_next;
            mcnt_reg <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_i_reg <= rd_i_next;
        lo_s_reg <= lo_s_next;
        hi_s_reg <= hi_s_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
    assign m_axis_tlast = olast_reg;

endmodule

[sv/tmc2d_checker.sv]
// port-level checks for the two-means clustering unit
module tmc2d_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic s_axis_tlast,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast,
    input logic pready
);

    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");

    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken after last point");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result after last transaction");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind two_means_clustering_2d_unit tmc2d_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tlast(m_axis_tlast), .pready(pready)
);

[test/tb_two_means_clustering_2d_unit.sv]
// testbench for the two-means clustering unit: scored against an internal predictor
`timescale 1ns / 1ps

module tb_two_means_clustering_2d_unit;

    localparam int NPTS = 64;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct packed {
        logic [5:0]  point_index;
        logic        cluster;
        logic [15:0] mean_a_x;
        logic [15:0] mean_a_y;
        logic [15:0] mean_b_x;
        logic [15:0] mean_b_y;
        logic        limit_hit;
        logic        empty_cluster;
        logic        last_result;
    } cluster_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    two_means_clustering_2d_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [7:0]       iter_cap;
    logic signed [15:0] pt_x [NPTS];
    logic signed [15:0] pt_y [NPTS];
    logic             pt_label [NPTS];
    int               pt_count;
    cluster_result_t  expected_q [$];

    int  error_count = 0;
    int  idle_cycles = 0;
    int  out_count = 0;
    int  seen_count = 0;
    int  sink_wait = 0;
    bit  sink_stall_on;
    bit  source_gap_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned dist_sq(longint signed px, longint signed py,
                                                longint signed mx, longint signed my);
        longint signed dx;
        longint signed dy;
        dx = px - mx;
        dy = py - my;
        return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    task automatic cluster_set();
        longint signed mean [4];
        longint signed sum [4];
        int members [2];
        int lo;
        int hi;
        int cap;
        int passes;
        bit changed;
        bit lab;
        bit hit;
        bit empty;
        cluster_result_t r;
        lo = 0;
        hi = 0;
        cap = (iter_cap == 0) ? 1 : iter_cap;
        for (int i = 1; i < pt_count; i++)
        begin
            if (int'(pt_x[i]) + int'(pt_y[i]) < int'(pt_x[lo]) + int'(pt_y[lo])) lo = i;
            if (int'(pt_x[i]) + int'(pt_y[i]) > int'(pt_x[hi]) + int'(pt_y[hi])) hi = i;
        end
        mean[0] = pt_x[lo];
        mean[1] = pt_y[lo];
        mean[2] = pt_x[hi];
        mean[3] = pt_y[hi];
        passes = 0;
        changed = 1'b1;
        members[0] = 0;
        members[1] = 0;
        while (changed && passes < cap)
        begin
            changed = (passes == 0);
            for (int k = 0; k < 4; k++) sum[k] = 0;
            members[0] = 0;
            members[1] = 0;
            for (int i = 0; i < pt_count; i++)
            begin
                lab = !(dist_sq(pt_x[i], pt_y[i], mean[0], mean[1])
                        < dist_sq(pt_x[i], pt_y[i], mean[2], mean[3]));
                if (lab != pt_label[i]) changed = 1'b1;
                pt_label[i] = lab;
                sum[2*lab] += pt_x[i];
                sum[2*lab+1] += pt_y[i];
                members[lab]++;
            end
            for (int k = 0; k < 2; k++)
            begin
                mean[2*k]   = (members[k] != 0) ? sum[2*k] / members[k] : 0;
                mean[2*k+1] = (members[k] != 0) ? sum[2*k+1] / members[k] : 0;
            end
            passes++;
        end
        hit = changed;
        empty = (members[0] == 0 || members[1] == 0);
        for (int i = 0; i < pt_count; i++)
        begin
            r.point_index   = 6'(i);
            r.cluster       = pt_label[i];
            r.mean_a_x      = 16'(mean[0]);
            r.mean_a_y      = 16'(mean[1]);
            r.mean_b_x      = 16'(mean[2]);
            r.mean_b_y      = 16'(mean[3]);
            r.limit_hit     = hit;
            r.empty_cluster = empty;
            r.last_result   = (i + 1 == pt_count);
            expected_q = {expected_q, r};
        end
        pt_count = 0;
    endtask

    task automatic predict_point(logic [15:0] x, logic [15:0] y, logic last);
        if (pt_count < NPTS)
        begin
            pt_x[pt_count] = x;
            pt_y[pt_count] = y;
            pt_count++;
        end
        if (last) cluster_set();
    endtask

    task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
        int gap;
        gap = source_gap_on ? $urandom_range(0, 12) : 0;
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_point(x, y, last);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_max_iterations(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {tmc2d_pkg::CFG_MAX_ITER, 1'b0};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        iter_cap = value[7:0];
    endtask

    task automatic send_random_set(int n, int kind);
        logic [15:0] x;
        logic [15:0] y;
        for (int i = 0; i < n; i++)
        begin
            unique case (kind)
                0: begin x = 16'($urandom); y = 16'($urandom); end
                1:
                begin
                    x = 16'($urandom_range(0, 200));
                    y = 16'($urandom_range(0, 200));
                end
                default:
                begin
                    x = ($urandom_range(0, 1) ? 16'sd20000 : -16'sd20000)
                        + 16'($urandom_range(0, 63)) - 16'sd32;
                    y = ($urandom_range(0, 1) ? 16'sd20000 : -16'sd20000)
                        + 16'($urandom_range(0, 63)) - 16'sd32;
                end
            endcase
            send_point(x, y, i == n - 1);
        end
    endtask

    task automatic test_directed();
        // single point, extremes and ties
        send_point(16'h7fff, 16'h8000, 1'b1);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1);
        send_point(16'd5, 16'd5, 1'b0);
        send_point(16'd5, 16'd5, 1'b0);
        send_point(16'd5, 16'd5, 1'b1);
        send_point(16'hfffe, 16'd2, 1'b0);
        send_point(16'd2, 16'hfffe, 1'b0);
        send_point(16'd0, 16'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_store_overflow();
        send_random_set(70, 0);
        wait_drained();
        for (int i = 0; i < 66; i++) send_point(16'($urandom), 16'($urandom), 1'b0);
        send_point(16'($urandom), 16'($urandom), 1'b1);
        wait_drained();
    endtask

    task automatic test_iteration_caps();
        write_max_iterations(32'd1);
        send_random_set(12, 2);
        send_random_set(9, 0);
        wait_drained();
        write_max_iterations(32'd0);
        send_random_set(8, 0);
        wait_drained();
        write_max_iterations(32'hffffff02);
        send_random_set(16, 0);
        wait_drained();
        write_max_iterations(32'd255);
        send_random_set(20, 1);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int n;
        for (int s = 0; s < 11; s++)
        begin
            source_gap_on = $urandom_range(0, 3) != 0;
            sink_stall_on = $urandom_range(0, 3) != 0;
            n = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 16);
            send_random_set(n, $urandom_range(0, 2));
            if (s == 5)
            begin
                wait_drained();
                write_max_iterations($urandom_range(1, 8));
            end
        end
        wait_drained();
    endtask

    // ready stalls, a wait drawn after each result
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_count != seen_count)
            begin
                seen_count = out_count;
                sink_wait = sink_stall_on ? $urandom_range(0, 12) : 0;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        cluster_result_t got;
        cluster_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            out_count++;
            got.point_index   = m_axis_tdata[5:0];
            got.cluster       = m_axis_tdata[6];
            got.mean_a_x      = m_axis_tdata[22:7];
            got.mean_a_y      = m_axis_tdata[38:23];
            got.mean_b_x      = m_axis_tdata[54:39];
            got.mean_b_y      = m_axis_tdata[70:55];
            got.limit_hit     = m_axis_tdata[71];
            got.empty_cluster = m_axis_tdata[72];
            got.last_result   = m_axis_tlast;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected transaction %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t mismatch: expected %h actual %h", $time, want, got);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        iter_cap      = tmc2d_pkg::MAX_ITER_RESET;
        pt_count      = 0;
        sink_stall_on = 1'b0;
        source_gap_on = 1'b0;
        for (int i = 0; i < NPTS; i++) pt_label[i] = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        source_gap_on = 1'b1;
        sink_stall_on = 1'b1;
        test_store_overflow();
        test_iteration_caps();
        test_random_sets();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
